>>> rtl/flc_pkg.sv
// ----------------------------------------------------------------------------
// Flow linearization package
// Shared widths, codes and payload types of the flow linearization block.
// ----------------------------------------------------------------------------
package flc_pkg;

   localparam int ADC_BITS      = 12;
   localparam int IDX_BITS      = ADC_BITS - 2;
   localparam int TINDEX_BITS   = 10;
   localparam int FLOW_BITS     = 16;
   localparam int COUNT_BITS    = 8;
   localparam int FSUM_BITS     = 24;
   localparam int WSUM_BITS     = 20;
   localparam int DIV_BITS      = 24;
   localparam int DCNT_BITS     = $clog2(DIV_BITS);
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [DCNT_BITS-1:0] DIV_LAST = DCNT_BITS'(DIV_BITS - 1);

   localparam logic [1:0] OP_SAMPLE  = 2'd0;
   localparam logic [1:0] OP_WRITE_X = 2'd1;
   localparam logic [1:0] OP_WRITE_Y = 2'd2;

   localparam logic REG_SAMPLE_COUNT = 1'b0;
   localparam logic REG_STREAMING    = 1'b1;

   localparam logic signed [FLOW_BITS-1:0] FLOW_MAX = 16'sh7FFF;
   localparam logic signed [FLOW_BITS-1:0] FLOW_MIN = 16'sh8000;

   typedef struct packed {
      logic [1:0]                  op;
      logic [ADC_BITS-1:0]         raw_flow_x;
      logic [ADC_BITS-1:0]         raw_flow_y;
      logic [ADC_BITS-1:0]         adc_work_x;
      logic [ADC_BITS-1:0]         adc_work_y;
      logic [TINDEX_BITS-1:0]      table_index;
      logic signed [FLOW_BITS-1:0] table_value;
   } req_type;

   typedef struct packed {
      logic signed [FLOW_BITS-1:0] flow_x_avg;
      logic signed [FLOW_BITS-1:0] flow_y_avg;
      logic [ADC_BITS-1:0]         work_x_avg;
      logic [ADC_BITS-1:0]         work_y_avg;
      logic signed [FLOW_BITS-1:0] flow_x_min;
      logic signed [FLOW_BITS-1:0] flow_x_max;
      logic signed [FLOW_BITS-1:0] flow_y_min;
      logic signed [FLOW_BITS-1:0] flow_y_max;
   } rsp_type;

   typedef struct packed {
      logic [COUNT_BITS-1:0] sample_count;
      logic                  streaming;
      logic                  rearm;
   } cfg_type;

   typedef struct packed {
      logic clr_en;
      logic take;
      logic exec;
      logic accum;
      logic div_init;
      logic div_step;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic       clr_last;
      logic [1:0] op;
      logic       left_gt1;
   } status_type;

endpackage

>>> rtl/flc_csr.sv
// ----------------------------------------------------------------------------
// Flow linearization register port
// Holds the sample count and mode registers and signals a re-arm on writes.
// ----------------------------------------------------------------------------
module flc_csr import flc_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready,
   output cfg_type                  cfg
);

   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  stream_ff, stream_in;
   logic                  rearm_ff, rearm_in;
   logic                  wr;

   assign wr = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      count_in  = count_ff;
      stream_in = stream_ff;
      rearm_in  = wr;
      if (wr) begin
         if (csr_paddr[2] == REG_SAMPLE_COUNT) begin
            count_in = (csr_pwdata[COUNT_BITS-1:0] == '0) ?
                       COUNT_BITS'(1) : csr_pwdata[COUNT_BITS-1:0];
         end else begin
            stream_in = csr_pwdata[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= COUNT_BITS'(1);
         stream_ff <= 1'b0;
         rearm_ff  <= 1'b0;
      end else begin
         count_ff  <= count_in;
         stream_ff <= stream_in;
         rearm_ff  <= rearm_in;
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_STREAMING) ?
                       CSR_DATA_BITS'(stream_ff) : CSR_DATA_BITS'(count_ff);

   assign cfg.sample_count = count_ff;
   assign cfg.streaming    = stream_ff;
   assign cfg.rearm        = rearm_ff;

endmodule

>>> rtl/flc_ctrl.sv
// ----------------------------------------------------------------------------
// Flow linearization controller
// Sequences table clearing, lookup, accumulation, division and result output.
// ----------------------------------------------------------------------------
module flc_ctrl import flc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  cfg_type    cfg,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [6:0] {
      S_CLEAR = 7'b0000001,
      S_IDLE  = 7'b0000010,
      S_EXEC  = 7'b0000100,
      S_ACCUM = 7'b0001000,
      S_DINIT = 7'b0010000,
      S_DIV   = 7'b0100000,
      S_EMIT  = 7'b1000000
   } state_type;

   state_type             state_ff, state_in;
   logic [DCNT_BITS-1:0]  cnt_ff, cnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clr_en = 1'b1;
            if (status.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.take = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            state_in = (status.op == OP_SAMPLE) ? S_ACCUM : S_IDLE;
         end
         S_ACCUM: begin
            cmd.accum = 1'b1;
            if (cfg.streaming) state_in = S_EMIT;
            else if (status.left_gt1) state_in = S_IDLE;
            else state_in = S_DINIT;
         end
         S_DINIT: begin
            cmd.div_init = 1'b1;
            cnt_in       = '0;
            state_in     = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) state_in = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      rsp_valid_in = cmd.emit || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   a_emit_shows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT && !rsp_stall) |=> rsp_valid_ff)
      else $error("A result ready for a free output was not presented.");

   a_div_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV && cnt_ff == DIV_LAST) |=> (state_ff == S_EMIT))
      else $error("The division did not end after the last step.");

endmodule

>>> rtl/flc_dp.sv
// ----------------------------------------------------------------------------
// Flow linearization datapath
// Lookup tables, block accumulators, serial dividers and the result register.
// ----------------------------------------------------------------------------
module flc_dp import flc_pkg::*; #(
   parameter int TABLE_DEPTH = 1024
) (
   input  logic       clock,
   input  logic       reset,
   input  req_type    req_data,
   input  cfg_type    cfg,
   input  cmd_type    cmd,
   output status_type status,
   output rsp_type    rsp_data
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_DEPTH - 1);

   req_type                     item_ff;
   logic [AW-1:0]               clr_ff, clr_in;
   logic signed [FLOW_BITS-1:0] x_mem [TABLE_DEPTH];
   logic signed [FLOW_BITS-1:0] y_mem [TABLE_DEPTH];
   logic signed [FLOW_BITS-1:0] fx_ff, fy_ff;
   logic [AW-1:0]               x_addr, y_addr, w_addr;
   logic                        w_ok;

   logic signed [FSUM_BITS-1:0] xs_ff, xs_in, ys_ff, ys_in;
   logic [WSUM_BITS-1:0]        xw_ff, xw_in, yw_ff, yw_in;
   logic signed [FLOW_BITS-1:0] xlo_ff, xlo_in, xhi_ff, xhi_in;
   logic signed [FLOW_BITS-1:0] ylo_ff, ylo_in, yhi_ff, yhi_in;
   logic [COUNT_BITS-1:0]       left_ff, left_in;

   logic [DIV_BITS-1:0]   dq_ff [4];
   logic [DIV_BITS-1:0]   dq_in [4];
   logic [COUNT_BITS-1:0] rem_ff [4];
   logic [COUNT_BITS-1:0] rem_in [4];
   logic [COUNT_BITS:0]   part [4];
   logic [1:0]            neg_ff, neg_in;
   logic [FSUM_BITS-1:0]  mag_x, mag_y;
   logic [DIV_BITS-1:0]   qx, qy;
   rsp_type               rsp_ff, rsp_in;

   function automatic logic [AW-1:0] table_addr(input logic [ADC_BITS-1:0] raw);
      logic [IDX_BITS-1:0] idx;
      idx = raw[ADC_BITS-1:2];
      if (32'(idx) >= TABLE_DEPTH) return LAST_ADDR;
      return AW'(idx);
   endfunction

   assign x_addr = table_addr(item_ff.raw_flow_x);
   assign y_addr = table_addr(item_ff.raw_flow_y);
   assign w_addr = AW'(item_ff.table_index);
   assign w_ok   = (32'(item_ff.table_index) < TABLE_DEPTH);
   assign clr_in = clr_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clr_en) begin
         clr_ff <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) item_ff <= req_data;
   end

   always_ff @(posedge clock) begin
      if (cmd.clr_en) begin
         x_mem[clr_ff] <= FLOW_BITS'(clr_ff);
      end else if (cmd.exec && item_ff.op == OP_WRITE_X && w_ok) begin
         x_mem[w_addr] <= item_ff.table_value;
      end
      if (cmd.exec) fx_ff <= x_mem[x_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.clr_en) begin
         y_mem[clr_ff] <= FLOW_BITS'(clr_ff);
      end else if (cmd.exec && item_ff.op == OP_WRITE_Y && w_ok) begin
         y_mem[w_addr] <= item_ff.table_value;
      end
      if (cmd.exec) fy_ff <= y_mem[y_addr];
   end

   always_comb begin
      xs_in   = xs_ff;
      ys_in   = ys_ff;
      xw_in   = xw_ff;
      yw_in   = yw_ff;
      xlo_in  = xlo_ff;
      xhi_in  = xhi_ff;
      ylo_in  = ylo_ff;
      yhi_in  = yhi_ff;
      left_in = left_ff;
      if (cfg.rearm || (cmd.emit && !cfg.streaming)) begin
         xs_in   = '0;
         ys_in   = '0;
         xw_in   = '0;
         yw_in   = '0;
         xlo_in  = FLOW_MAX;
         ylo_in  = FLOW_MAX;
         xhi_in  = FLOW_MIN;
         yhi_in  = FLOW_MIN;
         left_in = cfg.sample_count;
      end else if (cmd.accum && !cfg.streaming) begin
         xs_in = xs_ff + FSUM_BITS'(fx_ff);
         ys_in = ys_ff + FSUM_BITS'(fy_ff);
         xw_in = xw_ff + WSUM_BITS'(item_ff.adc_work_x);
         yw_in = yw_ff + WSUM_BITS'(item_ff.adc_work_y);
         if (fx_ff < xlo_ff) xlo_in = fx_ff;
         if (fx_ff > xhi_ff) xhi_in = fx_ff;
         if (fy_ff < ylo_ff) ylo_in = fy_ff;
         if (fy_ff > yhi_ff) yhi_in = fy_ff;
         if (left_ff > COUNT_BITS'(1)) left_in = left_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         xs_ff   <= '0;
         ys_ff   <= '0;
         xw_ff   <= '0;
         yw_ff   <= '0;
         xlo_ff  <= FLOW_MAX;
         ylo_ff  <= FLOW_MAX;
         xhi_ff  <= FLOW_MIN;
         yhi_ff  <= FLOW_MIN;
         left_ff <= COUNT_BITS'(1);
      end else begin
         xs_ff   <= xs_in;
         ys_ff   <= ys_in;
         xw_ff   <= xw_in;
         yw_ff   <= yw_in;
         xlo_ff  <= xlo_in;
         ylo_ff  <= ylo_in;
         xhi_ff  <= xhi_in;
         yhi_ff  <= yhi_in;
         left_ff <= left_in;
      end
   end

   assign mag_x = xs_ff[FSUM_BITS-1] ? (~xs_ff + 1'b1) : xs_ff;
   assign mag_y = ys_ff[FSUM_BITS-1] ? (~ys_ff + 1'b1) : ys_ff;

   // Four restoring dividers by the sample count, one quotient bit per step.
   always_comb begin
      neg_in = neg_ff;
      for (int i = 0; i < 4; i++) begin
         dq_in[i]  = dq_ff[i];
         rem_in[i] = rem_ff[i];
         part[i]   = {rem_ff[i], dq_ff[i][DIV_BITS-1]};
      end
      if (cmd.div_init) begin
         neg_in    = {ys_ff[FSUM_BITS-1], xs_ff[FSUM_BITS-1]};
         dq_in[0]  = DIV_BITS'(mag_x);
         dq_in[1]  = DIV_BITS'(mag_y);
         dq_in[2]  = DIV_BITS'(xw_ff);
         dq_in[3]  = DIV_BITS'(yw_ff);
         for (int i = 0; i < 4; i++) rem_in[i] = '0;
      end else if (cmd.div_step) begin
         for (int i = 0; i < 4; i++) begin
            if (part[i] >= {1'b0, cfg.sample_count}) begin
               rem_in[i] = COUNT_BITS'(part[i] - {1'b0, cfg.sample_count});
               dq_in[i]  = {dq_ff[i][DIV_BITS-2:0], 1'b1};
            end else begin
               rem_in[i] = part[i][COUNT_BITS-1:0];
               dq_in[i]  = {dq_ff[i][DIV_BITS-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      neg_ff <= neg_in;
      for (int i = 0; i < 4; i++) begin
         dq_ff[i]  <= dq_in[i];
         rem_ff[i] <= rem_in[i];
      end
   end

   assign qx = neg_ff[0] ? (~dq_ff[0] + 1'b1) : dq_ff[0];
   assign qy = neg_ff[1] ? (~dq_ff[1] + 1'b1) : dq_ff[1];

   always_comb begin
      if (cfg.streaming) begin
         rsp_in.flow_x_avg = fx_ff;
         rsp_in.flow_y_avg = fy_ff;
         rsp_in.work_x_avg = item_ff.adc_work_x;
         rsp_in.work_y_avg = item_ff.adc_work_y;
         rsp_in.flow_x_min = fx_ff;
         rsp_in.flow_x_max = fx_ff;
         rsp_in.flow_y_min = fy_ff;
         rsp_in.flow_y_max = fy_ff;
      end else begin
         rsp_in.flow_x_avg = qx[FLOW_BITS-1:0];
         rsp_in.flow_y_avg = qy[FLOW_BITS-1:0];
         rsp_in.work_x_avg = dq_ff[2][ADC_BITS-1:0];
         rsp_in.work_y_avg = dq_ff[3][ADC_BITS-1:0];
         rsp_in.flow_x_min = xlo_ff;
         rsp_in.flow_x_max = xhi_ff;
         rsp_in.flow_y_min = ylo_ff;
         rsp_in.flow_y_max = yhi_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) rsp_ff <= rsp_in;
   end

   assign rsp_data        = rsp_ff;
   assign status.clr_last = (clr_ff == LAST_ADDR);
   assign status.op       = item_ff.op;
   assign status.left_gt1 = (left_ff > COUNT_BITS'(1));

   a_left_nonzero: assert property (@(posedge clock) disable iff (reset)
      left_ff != '0)
      else $error("The remaining sample count reached zero.");

   a_range_order: assert property (@(posedge clock) disable iff (reset)
      (left_ff != cfg.sample_count && !cfg.rearm) |-> (xlo_ff <= xhi_ff && ylo_ff <= yhi_ff))
      else $error("Minimum exceeds maximum inside a partly filled block.");

endmodule

>>> rtl/flow_lut_window_avg_min_max.sv
// ----------------------------------------------------------------------------
// Flow linearization with block average, minimum and maximum
// Linearizes two flow readings through lookup tables and reports per-block
// averages with minimum and maximum, or every sample in streaming mode.
// ----------------------------------------------------------------------------
// Usage: items enter on req_valid/req_stall and results leave on
// rsp_valid/rsp_stall; a transaction completes when valid is high and stall
// is low. Sample count and mode are written through the csr_ port, and any
// write restarts the current block. After reset the block walks both tables
// once to load them with identity values, one entry per cycle, and holds
// req_stall high during that pass. One item is in work at a time. A table
// write passes the execute state, and a sample that does not end a block
// also the accumulate state. A streaming sample goes from accumulate to emit.
// A sample that ends a block runs the 24-step serial divider before its
// result is emitted. The result sits in an output register, so a new item
// is accepted while it waits; when the receiver stalls, the next result
// waits in the controller until the register is free.
// ----------------------------------------------------------------------------
module flow_lut_window_avg_min_max import flc_pkg::*; #(
   parameter int TABLE_DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  req_type                  req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output rsp_type                  rsp_data,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   flc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   flc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cfg       (cfg),
      .status    (status),
      .cmd       (cmd)
   );

   flc_dp #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cfg      (cfg),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule
